// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for implication checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// ilp_pkg
// shared types and codes of the integer literal parser
// ----------------------------------------------------------------------------
package ilp_pkg;

   localparam logic [3:0] ERR_OK            = 4'd0;
   localparam logic [3:0] ERR_MISSING_VALUE = 4'd1;
   localparam logic [3:0] ERR_MISSING_DIGIT = 4'd2;
   localparam logic [3:0] ERR_INVALID       = 4'd3;
   localparam logic [3:0] ERR_BAD_DIGIT     = 4'd4;
   localparam logic [3:0] ERR_TOO_LARGE     = 4'd5;
   localparam logic [3:0] ERR_NEG_UNSIGNED  = 4'd6;
   localparam logic [3:0] ERR_RANGE         = 4'd7;
   localparam logic [3:0] ERR_UNTYPED       = 4'd8;

   localparam logic [1:0] CSR_TARGET_BITS   = 2'd0;
   localparam logic [1:0] CSR_TARGET_SIGNED = 2'd1;
   localparam logic [1:0] CSR_UNTYPED_MODE  = 2'd2;

   localparam logic [6:0] TARGET_BITS_RESET = 7'd32;

   typedef enum logic [2:0] {
      PH_LEAD    = 3'd0,
      PH_SIGN    = 3'd1,
      PH_SIGN_WS = 3'd2,
      PH_HELD0   = 3'd3,
      PH_PFX     = 3'd4,
      PH_PFX_WS  = 3'd5,
      PH_DIG     = 3'd6,
      PH_DIG_WS  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } radix_type;

   typedef struct packed {
      logic [7:0] character;
      logic       has_char;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic [63:0] value_out;
      logic [3:0]  error_code;
   } rsp_word_type;

   typedef struct packed {
      logic       has_char;
      logic       is_last;
      logic       is_space;
      logic       is_sign;
      logic       is_minus;
      logic       is_zero;
      logic       is_x;
      logic       is_b;
      logic       is_under;
      logic       is_digit;
      logic [3:0] digit;
   } cls_type;

   typedef struct packed {
      logic [3:0]  err;
      logic [63:0] mag;
      logic        neg;
   } fin_type;

   typedef struct packed {
      logic [6:0] target_bits;
      logic       target_signed;
      logic       untyped_mode;
   } cfg_type;

endpackage

// ===== src/ilp_front.sv =====
// ----------------------------------------------------------------------------
// ilp_front
// character classifier and two-entry word queue toward the parser
// ----------------------------------------------------------------------------
module ilp_front import ilp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   output logic         q_valid,
   output cls_type      q_word,
   input  logic         q_pop
);

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] HEX_LOW_OFS = 8'h57;
   localparam logic [7:0] HEX_UP_OFS  = 8'h37;

   cls_type    cls;
   logic [7:0] ch;
   logic [7:0] dig8;
   logic       wr_en;
   logic       rd_en;

   cls_type    mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;

   always_comb begin
      ch   = req_word.character;
      dig8 = 8'd0;
      cls  = '0;
      cls.has_char = req_word.has_char;
      cls.is_last  = req_word.is_last;
      cls.is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
      cls.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
      cls.is_minus = (ch == CH_MINUS);
      cls.is_zero  = (ch == CH_ZERO);
      cls.is_x     = (ch == CH_LX) || (ch == CH_UX);
      cls.is_b     = (ch == CH_LB) || (ch == CH_UB);
      cls.is_under = (ch == CH_UNDER);
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         cls.is_digit = 1'b1;
         dig8 = ch - CH_ZERO;
      end else if (ch >= CH_LA && ch <= CH_LF) begin
         cls.is_digit = 1'b1;
         dig8 = ch - HEX_LOW_OFS;
      end else if (ch >= CH_UA && ch <= CH_UF) begin
         cls.is_digit = 1'b1;
         dig8 = ch - HEX_UP_OFS;
      end
      cls.digit = dig8[3:0];
   end

   // words with neither a character nor an end mark change nothing
   assign full    = (count_ff == 2'd2);
   assign wr_en   = push && !full && (req_word.has_char || req_word.is_last);
   assign q_valid = (count_ff != 2'd0);
   assign rd_en   = q_pop && q_valid;
   assign q_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== src/ilp_parse.sv =====
// ----------------------------------------------------------------------------
// ilp_parse
// literal state machine with digit accumulator and end-of-literal snapshot
// ----------------------------------------------------------------------------
module ilp_parse import ilp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cls_type q_word,
   output logic    q_pop,
   output logic    fin_valid,
   output fin_type fin_word,
   input  logic    fin_ready
);

   logic [63:0] acc_ff, acc_in;
   phase_type   phase_ff, phase_in;
   radix_type   radix_ff, radix_in;
   logic        neg_ff, neg_in;
   logic        seen_ff, seen_in;
   logic [3:0]  err_ff, err_in;
   logic        pfx_x_ff, pfx_x_in;
   logic        fin_valid_ff, fin_valid_in;
   fin_type     fin_ff, fin_in;

   logic [63:0] acc_n;
   phase_type   phase_n;
   radix_type   radix_n;
   logic        neg_n;
   logic        seen_n;
   logic [3:0]  err_n;
   logic        pfx_x_n;
   logic        do_take;
   logic [67:0] prod;
   logic        bad_digit;
   logic [3:0]  fin_err;
   logic        step;

   assign step      = q_valid && (!q_word.is_last || !fin_valid_ff || fin_ready);
   assign q_pop     = step;
   assign fin_valid = fin_valid_ff;
   assign fin_word  = fin_ff;

   always_comb begin
      acc_n   = acc_ff;
      phase_n = phase_ff;
      radix_n = radix_ff;
      neg_n   = neg_ff;
      seen_n  = seen_ff;
      err_n   = err_ff;
      pfx_x_n = pfx_x_ff;
      do_take = 1'b0;
      prod    = '0;
      bad_digit = 1'b0;
      fin_err = ERR_OK;

      if (q_word.has_char && err_ff == ERR_OK) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (q_word.is_space) begin
                  phase_n = PH_LEAD;
               end else if (q_word.is_sign) begin
                  neg_n   = q_word.is_minus;
                  phase_n = PH_SIGN;
               end else if (q_word.is_zero) begin
                  phase_n = PH_HELD0;
               end else begin
                  phase_n = PH_DIG;
                  do_take = 1'b1;
               end
            end
            PH_SIGN: begin
               if (q_word.is_space) begin
                  phase_n = PH_SIGN_WS;
               end else if (q_word.is_zero) begin
                  phase_n = PH_HELD0;
               end else begin
                  phase_n = PH_DIG;
                  do_take = 1'b1;
               end
            end
            PH_HELD0: begin
               if (q_word.is_space) begin
                  seen_n  = 1'b1;
                  phase_n = PH_DIG_WS;
               end else if (q_word.is_x || q_word.is_b) begin
                  pfx_x_n = q_word.is_x;
                  phase_n = PH_PFX;
               end else begin
                  seen_n  = 1'b1;
                  phase_n = PH_DIG;
                  do_take = 1'b1;
               end
            end
            PH_PFX: begin
               if (q_word.is_space) begin
                  phase_n = PH_PFX_WS;
               end else begin
                  radix_n = pfx_x_ff ? RADIX_HEX : RADIX_BIN;
                  phase_n = PH_DIG;
                  do_take = 1'b1;
               end
            end
            PH_DIG: begin
               if (q_word.is_space) begin
                  phase_n = PH_DIG_WS;
               end else begin
                  do_take = 1'b1;
               end
            end
            PH_SIGN_WS, PH_PFX_WS, PH_DIG_WS: begin
               if (!q_word.is_space) begin
                  err_n = ERR_INVALID;
               end
            end
            default: begin
               phase_n = phase_ff;
            end
         endcase
      end

      // one digit through the shift-and-add accumulator
      unique case (radix_n)
         RADIX_HEX: begin
            prod = {acc_ff, 4'b0000};
            bad_digit = 1'b0;
         end
         RADIX_BIN: begin
            prod = {3'b000, acc_ff, 1'b0};
            bad_digit = (q_word.digit >= 4'd2);
         end
         default: begin
            prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0};
            bad_digit = (q_word.digit >= 4'd10);
         end
      endcase
      prod = prod + {64'd0, q_word.digit};

      if (do_take && !q_word.is_under) begin
         if (!q_word.is_digit) begin
            err_n = ERR_INVALID;
         end else if (bad_digit) begin
            err_n = ERR_BAD_DIGIT;
         end else begin
            seen_n = 1'b1;
            if (prod[67:64] != 4'd0) begin
               err_n = ERR_TOO_LARGE;
            end else begin
               acc_n = prod[63:0];
            end
         end
      end

      // end of literal
      fin_err = err_n;
      if (err_n == ERR_OK) begin
         unique case (phase_n)
            PH_LEAD: begin
               fin_err = ERR_MISSING_VALUE;
            end
            PH_SIGN, PH_SIGN_WS: begin
               fin_err = ERR_MISSING_DIGIT;
            end
            PH_HELD0: begin
               fin_err = ERR_OK;
            end
            PH_PFX, PH_PFX_WS: begin
               fin_err = pfx_x_n ? ERR_INVALID : ERR_BAD_DIGIT;
            end
            default: begin
               fin_err = seen_n ? ERR_OK : ERR_MISSING_DIGIT;
            end
         endcase
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      phase_in = phase_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      err_in   = err_ff;
      pfx_x_in = pfx_x_ff;
      fin_in   = fin_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (step) begin
         if (q_word.is_last) begin
            acc_in   = 64'd0;
            phase_in = PH_LEAD;
            radix_in = RADIX_DEC;
            neg_in   = 1'b0;
            seen_in  = 1'b0;
            err_in   = ERR_OK;
            pfx_x_in = 1'b0;
            fin_valid_in = 1'b1;
            fin_in.err = fin_err;
            fin_in.mag = acc_n;
            fin_in.neg = neg_n;
         end else begin
            acc_in   = acc_n;
            phase_in = phase_n;
            radix_in = radix_n;
            neg_in   = neg_n;
            seen_in  = seen_n;
            err_in   = err_n;
            pfx_x_in = pfx_x_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         phase_ff     <= PH_LEAD;
         radix_ff     <= RADIX_DEC;
         neg_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         err_ff       <= ERR_OK;
         pfx_x_ff     <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         phase_ff     <= phase_in;
         radix_ff     <= radix_in;
         neg_ff       <= neg_in;
         seen_ff      <= seen_in;
         err_ff       <= err_in;
         pfx_x_ff     <= pfx_x_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

endmodule

// ===== src/ilp_check.sv =====
// ----------------------------------------------------------------------------
// ilp_check
// target range check, sign apply and two-entry result queue
// ----------------------------------------------------------------------------
module ilp_check import ilp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         fin_valid,
   input  fin_type      fin_word,
   output logic         fin_ready,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);

   logic [5:0]   sh;
   logic [5:0]   shm1;
   logic         no_width;
   logic [63:0]  mag;
   logic [3:0]   err;
   rsp_word_type res;
   logic         wr_en;
   logic         rd_en;
   logic         full_q;

   rsp_word_type mem_ff [2];
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;

   always_comb begin
      mag      = fin_word.mag;
      sh       = cfg.target_bits[5:0];
      shm1     = sh - 6'd1;
      no_width = (cfg.target_bits == 7'd0) || cfg.target_bits[6];
      err      = fin_word.err;
      if (err == ERR_OK) begin
         if (!cfg.target_signed) begin
            if (fin_word.neg) begin
               err = ERR_NEG_UNSIGNED;
            end else if (!no_width && (mag >> sh) != 64'd0) begin
               err = ERR_RANGE;
            end
         end else if (fin_word.neg) begin
            if (mag > {1'b1, 63'd0}) begin
               err = ERR_TOO_LARGE;
            end else if (!no_width && mag > (64'd1 << shm1)) begin
               err = ERR_RANGE;
            end
         end else begin
            if (mag[63]) begin
               err = ERR_TOO_LARGE;
            end else if (!no_width && (mag >> shm1) != 64'd0) begin
               err = ERR_RANGE;
            end
         end
      end
      if (cfg.untyped_mode && err >= ERR_MISSING_VALUE && err <= ERR_BAD_DIGIT) begin
         err = ERR_UNTYPED;
      end
      res.error_code = err;
      if (err != ERR_OK) begin
         res.value_out = 64'd0;
      end else if (fin_word.neg) begin
         res.value_out = 64'd0 - mag;
      end else begin
         res.value_out = mag;
      end
   end

   assign full_q    = (count_ff == 2'd2);
   assign fin_ready = !full_q;
   assign wr_en     = fin_valid && !full_q;
   assign empty     = (count_ff == 2'd0);
   assign rd_en     = pop && !empty;
   assign rsp_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

// ===== src/integer_literal_parse_range_check_unit.sv =====
// ----------------------------------------------------------------------------
// integer_literal_parse_range_check_unit
// streaming integer literal parser with radix prefix and target range check
//
// input side is a queue: one character word per push, accepted when full is
// low; the word marked last closes the literal and yields one result word
// result side is a queue: the oldest result is on rsp_word while empty is low,
// and pop takes it
// csr_we with csr_index writes target_bits, target_signed or untyped_mode;
// write only while no literal is in flight
// throughput: one character per cycle; the digit update is a single
// shift-and-add step and the parser takes one word each cycle, but holds
// a last word while the snapshot waits on a full result queue; a last word
// passes input queue, end-of-literal snapshot, range check and result queue
// reset clears both queues and the parse state; registers go to 32 bits,
// signed, untyped mode on
// when pop stays low the result queue fills after two results and the snapshot
// register keeps a third; the parser then holds at the next last word and the
// input queue fills and raises full
// ----------------------------------------------------------------------------
module integer_literal_parse_range_check_unit import ilp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_wdata
);

   `include "assert_macros.svh"

   cfg_type cfg_ff, cfg_in;
   logic    q_valid;
   cls_type q_word;
   logic    q_pop;
   logic    fin_valid;
   fin_type fin_word;
   logic    fin_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_BITS:   cfg_in.target_bits   = csr_wdata;
            CSR_TARGET_SIGNED: cfg_in.target_signed = csr_wdata[0];
            CSR_UNTYPED_MODE:  cfg_in.untyped_mode  = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_bits   <= TARGET_BITS_RESET;
         cfg_ff.target_signed <= 1'b1;
         cfg_ff.untyped_mode  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ilp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   ilp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .fin_valid (fin_valid),
      .fin_word  (fin_word),
      .fin_ready (fin_ready)
   );

   ilp_check u_check (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fin_valid (fin_valid),
      .fin_word  (fin_word),
      .fin_ready (fin_ready),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word)
   );

   `ASSERT_IMPL(a_err_zero_value, clock, reset,
      !empty && rsp_word.error_code != ERR_OK, rsp_word.value_out == 64'd0)
   `ASSERT_IMPL(a_err_code_range, clock, reset,
      !empty, rsp_word.error_code <= ERR_UNTYPED)
   `ASSERT_IMPL(a_untyped_remap, clock, reset,
      !empty && cfg_ff.untyped_mode,
      rsp_word.error_code == ERR_OK || rsp_word.error_code >= ERR_TOO_LARGE)
   `ASSERT_NEXT(a_snapshot_held, clock, reset,
      fin_valid && !fin_ready, fin_valid && $stable(fin_word))

endmodule
